/* rtl/urs_pkg.sv */
package urs_pkg;

	localparam int TIME_W = 48;
	localparam int VAL_W = 32;
	localparam int IDX_W = 8;
	localparam int PERIOD_W = 24;
	// Rounded quotient numerator: 33-bit magnitude times period plus half divisor.
	localparam int NUM_W = 58;
	localparam int PROD_W = 57;
	localparam int CNT_W = 6;

	typedef struct packed {
		logic [TIME_W-1:0] sample_time;
		logic [IDX_W-1:0] element_index;
		logic signed [VAL_W-1:0] sample_value;
		logic last_element;
	} in_word_t;

	typedef struct packed {
		logic [TIME_W-1:0] grid_time;
		logic [IDX_W-1:0] out_index;
		logic signed [VAL_W-1:0] grid_value;
		logic end_of_run;
		logic gap_overflow;
	} out_word_t;

endpackage

/* rtl/urs_div.sv */
module urs_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [urs_pkg::NUM_W-1:0] dividend,
	input logic [urs_pkg::TIME_W-1:0] divisor,
	output logic busy,
	output logic [urs_pkg::NUM_W-1:0] quotient
);
	import urs_pkg::*;

	logic busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] div_q;
	logic [NUM_W-1:0] quo_q;
	logic [TIME_W:0] shifted;
	logic [TIME_W:0] trial;

	// One quotient bit per cycle, restoring form; dividend bits shift out of
	// the top of quo_q while quotient bits shift in at the bottom.
	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign trial = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(NUM_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (!trial[TIME_W]) begin
				rem_q <= trial[TIME_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[TIME_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quotient = quo_q;

endmodule

/* rtl/uniform_grid_linear_resampler.sv */
// Channel  Direction  Handshake              Word
// in       input      in_valid / in_ready    in_data (urs_pkg::in_word_t)
// out      output     out_valid / out_ready  out_data (urs_pkg::out_word_t)
// cfg      input      cfg_we                 cfg_wdata (grid period, 24 bits)
// An element that yields no grid point leaves from S_CHK; one passed through
// also visits S_PASS; otherwise S_RD runs once and each grid point takes S_SUB,
// S_MUL, S_DST, S_DIV (waiting on the serial divider of the interpolation
// step), S_UPD and S_OUT. in_ready is high only while the sequencer is idle.
// A stalled output holds the sequencer before it loads the next word. Reset
// clears all control state; the value memory is not cleared.
module uniform_grid_linear_resampler #(
	parameter int ELEMENTS = 256,
	parameter int MAX_GAP = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input urs_pkg::in_word_t in_data,
	output logic out_valid,
	input logic out_ready,
	output urs_pkg::out_word_t out_data,
	input logic cfg_we,
	input logic [urs_pkg::PERIOD_W-1:0] cfg_wdata
);
	import urs_pkg::*;

	localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
	localparam int KW = $clog2(MAX_GAP + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CHK = 4'd1;
	localparam logic [3:0] S_PASS = 4'd2;
	localparam logic [3:0] S_RD = 4'd3;
	localparam logic [3:0] S_SUB = 4'd4;
	localparam logic [3:0] S_MUL = 4'd5;
	localparam logic [3:0] S_DST = 4'd6;
	localparam logic [3:0] S_DIV = 4'd7;
	localparam logic [3:0] S_UPD = 4'd8;
	localparam logic [3:0] S_OUT = 4'd9;

	logic [3:0] state_q;
	logic [PERIOD_W-1:0] period_q;
	logic [TIME_W-1:0] grid_now_q;
	logic [TIME_W-1:0] grid_pending_q;
	logic started_q;

	logic [TIME_W-1:0] t_q;
	logic [IDX_W-1:0] idx_q;
	logic signed [VAL_W-1:0] x_q;
	logic last_q;

	logic [TIME_W-1:0] den_q;
	logic [TIME_W-1:0] gt_q;
	logic [KW-1:0] k_q;
	logic ovf_q;
	logic signed [VAL_W-1:0] v_q;
	logic neg_q;
	logic [VAL_W:0] mag_q;
	logic [PROD_W-1:0] prod_q;

	logic out_valid_q;
	out_word_t out_q;

	logic [VAL_W-1:0] mem [ELEMENTS];
	logic [VAL_W-1:0] rd_q;
	logic mem_we;
	logic [VAL_W-1:0] mem_wdata;

	logic [PERIOD_W-1:0] p_eff;
	logic in_range;
	logic [TIME_W-1:0] diff_c;
	logic [TIME_W-1:0] span_c;
	logic slot_free;
	logic eor_c;
	logic [VAL_W:0] d_c;
	logic signed [VAL_W+27:0] sum_c;
	logic signed [VAL_W-1:0] sat_c;
	logic [NUM_W-1:0] num_c;
	logic div_start;
	logic div_busy;
	logic [NUM_W-1:0] div_quo;

	assign p_eff = (period_q == '0) ? PERIOD_W'(1) : period_q;
	assign in_range = 11'(idx_q) < 11'(ELEMENTS);
	assign diff_c = t_q - grid_now_q;
	assign span_c = 48'(p_eff) * 48'(MAX_GAP);
	assign slot_free = !out_valid_q || out_ready;
	assign eor_c = (den_q <= 48'(p_eff)) || (k_q == KW'(MAX_GAP));
	assign d_c = {x_q[VAL_W-1], x_q} - {v_q[VAL_W-1], v_q};
	assign num_c = {1'b0, prod_q} + {11'b0, den_q[TIME_W-1:1]};
	assign div_start = (state_q == S_DST);

	// Interpolation step: previous value moved toward the sample by the
	// rounded quotient, then clamped to the 32-bit range.
	assign sum_c = neg_q ? ({{28{v_q[VAL_W-1]}}, v_q} - $signed({2'b0, div_quo}))
		: ({{28{v_q[VAL_W-1]}}, v_q} + $signed({2'b0, div_quo}));
	always_comb begin
		if (sum_c > 60'sh0000_0000_7FFF_FFFF) begin
			sat_c = 32'sh7FFF_FFFF;
		end else if (sum_c < -60'sh0000_0000_8000_0000) begin
			sat_c = 32'sh8000_0000;
		end else begin
			sat_c = sum_c[VAL_W-1:0];
		end
	end

	assign mem_we = ((state_q == S_CHK) && !started_q && in_range)
		|| ((state_q == S_OUT) && slot_free && eor_c);
	assign mem_wdata = (state_q == S_CHK) ? x_q : v_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[AW'(idx_q)] <= mem_wdata;
		end
		rd_q <= mem[AW'(idx_q)];
	end

	urs_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(num_c),
		.divisor(den_q),
		.busy(div_busy),
		.quotient(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			period_q <= PERIOD_W'(1000);
			grid_now_q <= '0;
			grid_pending_q <= '0;
			started_q <= 1'b0;
			out_valid_q <= 1'b0;
			k_q <= '0;
		end else begin
			if (cfg_we) begin
				period_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					k_q <= '0;
					if (!started_q) begin
						if (in_range) begin
							state_q <= S_PASS;
						end else begin
							if (last_q) begin
								grid_now_q <= t_q;
								grid_pending_q <= t_q;
								started_q <= 1'b1;
							end
							state_q <= S_IDLE;
						end
					end else if (!in_range) begin
						if (last_q) begin
							grid_now_q <= grid_pending_q;
						end
						state_q <= S_IDLE;
					end else if (t_q > grid_now_q) begin
						state_q <= S_RD;
					end else begin
						grid_pending_q <= grid_now_q;
						state_q <= S_IDLE;
					end
				end
				S_PASS: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						if (last_q) begin
							grid_now_q <= t_q;
							grid_pending_q <= t_q;
							started_q <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_RD: state_q <= S_SUB;
				S_SUB: state_q <= S_MUL;
				S_MUL: state_q <= S_DST;
				S_DST: state_q <= S_DIV;
				S_DIV: begin
					if (!div_busy) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					k_q <= k_q + 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						if (eor_c) begin
							grid_pending_q <= gt_q;
							if (last_q) begin
								grid_now_q <= gt_q;
							end
							state_q <= S_IDLE;
						end else begin
							state_q <= S_SUB;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			t_q <= in_data.sample_time;
			idx_q <= in_data.element_index;
			x_q <= in_data.sample_value;
			last_q <= in_data.last_element;
		end
		if (state_q == S_CHK) begin
			den_q <= diff_c;
			gt_q <= grid_now_q;
			ovf_q <= diff_c > span_c;
		end
		if (state_q == S_RD) begin
			v_q <= rd_q;
		end
		if (state_q == S_SUB) begin
			neg_q <= d_c[VAL_W];
			mag_q <= d_c[VAL_W] ? (~d_c + 1'b1) : d_c;
		end
		if (state_q == S_MUL) begin
			prod_q <= mag_q * p_eff;
		end
		if (state_q == S_UPD) begin
			v_q <= sat_c;
			gt_q <= gt_q + 48'(p_eff);
		end
		if (state_q == S_OUT && slot_free && !eor_c) begin
			den_q <= den_q - 48'(p_eff);
		end
		if (state_q == S_PASS && slot_free) begin
			out_q <= '{grid_time: t_q, out_index: idx_q, grid_value: x_q,
				end_of_run: 1'b1, gap_overflow: 1'b0};
		end
		if (state_q == S_OUT && slot_free) begin
			out_q <= '{grid_time: gt_q, out_index: idx_q, grid_value: v_q,
				end_of_run: eor_c, gap_overflow: ovf_q};
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

`ifndef SYNTHESIS
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= KW'(MAX_GAP))
		else $error("grid point count past the cap");
	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == S_DIV)
		else $error("divider busy outside its wait state");
	a_started_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |=> started_q)
		else $error("origin flag cleared after start");
	a_load_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> $stable(out_q))
		else $error("output word overwritten while stalled");
`endif

endmodule
